FILE: rtl/ihds_pkg.sv
`default_nettype none
package ihds_pkg;

    localparam int POINTS = 64;
    localparam int IDX_W = 6;
    localparam int TEMP_W = 24;
    localparam int RATIO_W = 24;
    localparam int MU_W = 32;
    localparam int MR_W = 32;
    localparam int DEN_W = 33;
    localparam int NUM_W = 64;
    localparam int QUO_W = 48;

    localparam logic [2:0] REG_RATIO = 3'd0;
    localparam logic [2:0] REG_GAIN = 3'd1;
    localparam logic [2:0] REG_INIT = 3'd2;
    localparam logic [2:0] REG_BOUND = 3'd3;
    localparam logic [2:0] REG_B1_LO = 3'd4;
    localparam logic [2:0] REG_B1_HI = 3'd5;
    localparam logic [2:0] REG_B2_LO = 3'd6;
    localparam logic [2:0] REG_B2_HI = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_FWD_READ,
        ST_FWD_DEN,
        ST_FWD_DIVE,
        ST_FWD_DIVD,
        ST_FWD_WRITE,
        ST_BWD_READ,
        ST_BWD_MUL,
        ST_BWD_WRITE,
        ST_EMIT_READ,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic fill;
        logic fwd_read;
        logic fwd_den;
        logic div_start_e;
        logic div_start_d;
        logic fwd_write;
        logic bwd_read;
        logic bwd_mul;
        logic bwd_write;
        logic emit_read;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/ihds_ram.sv
`default_nettype none
module ihds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/ihds_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ihds_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [ihds_pkg::NUM_W-1:0] num,
    input  wire logic [ihds_pkg::DEN_W-1:0] den,
    output logic                            busy,
    output logic [ihds_pkg::QUO_W-1:0]      quo
);
    localparam int CNT_W = $clog2(ihds_pkg::NUM_W + 1);
    localparam int REM_W = ihds_pkg::DEN_W + 1;

    logic [ihds_pkg::NUM_W-1:0] sh_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [ihds_pkg::DEN_W-1:0] den_reg;
    logic [ihds_pkg::QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [REM_W-1:0]           trial;
    logic [REM_W-1:0]           diff;

    assign trial = {rem_reg[REM_W-2:0], sh_reg[ihds_pkg::NUM_W-1]};
    assign diff = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(ihds_pkg::NUM_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (start) begin
            sh_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            sh_reg <= {sh_reg[ihds_pkg::NUM_W-2:0], 1'b0};
            if (!diff[REM_W-1]) begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[ihds_pkg::QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[ihds_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0) || start;
    assign quo = quo_reg;
endmodule
`default_nettype wire

FILE: rtl/ihds_datapath.sv
`default_nettype none
module ihds_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ihds_pkg::cmd_t              cmd,
    output ihds_pkg::status_t                status,
    input  wire logic [ihds_pkg::RATIO_W-1:0] ratio,
    input  wire logic [ihds_pkg::TEMP_W-1:0] gain,
    input  wire logic [ihds_pkg::TEMP_W-1:0] init_temp,
    input  wire logic [ihds_pkg::TEMP_W-1:0] bound_temp,
    input  wire logic [ihds_pkg::IDX_W-1:0]  b1_lo,
    input  wire logic [ihds_pkg::IDX_W-1:0]  b1_hi,
    input  wire logic [ihds_pkg::IDX_W-1:0]  b2_lo,
    input  wire logic [ihds_pkg::IDX_W-1:0]  b2_hi,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [ihds_pkg::IDX_W-1:0]       m_idx,
    output logic [ihds_pkg::TEMP_W-1:0]      m_temp,
    output logic                             m_last
);
    localparam int IW = ihds_pkg::IDX_W;
    localparam int TW = ihds_pkg::TEMP_W;
    localparam logic [IW-1:0] LAST = IW'(ihds_pkg::POINTS - 1);

    logic [IW-1:0] idx;
    logic [IW-1:0] idx_prev;
    assign idx = cmd.idx;
    assign idx_prev = idx - 1'b1;

    // Profile memory, written in fill and in back substitution.
    logic          prof_we;
    logic [IW-1:0] prof_waddr;
    logic [TW-1:0] prof_wdata;
    logic [IW-1:0] prof_raddr;
    logic [TW-1:0] prof_rdata;

    logic [31:0] mu_rdata, mr_rdata;
    logic        coef_we;
    logic [31:0] mu_wdata, mr_wdata;
    logic [IW-1:0] coef_raddr;

    ihds_ram #(.WIDTH(TW), .DEPTH(ihds_pkg::POINTS)) u_prof (
        .aclk(aclk), .we(prof_we), .waddr(prof_waddr), .wdata(prof_wdata),
        .raddr(prof_raddr), .rdata(prof_rdata));
    ihds_ram #(.WIDTH(32), .DEPTH(ihds_pkg::POINTS)) u_mu (
        .aclk(aclk), .we(coef_we), .waddr(idx), .wdata(mu_wdata),
        .raddr(coef_raddr), .rdata(mu_rdata));
    ihds_ram #(.WIDTH(32), .DEPTH(ihds_pkg::POINTS)) u_mr (
        .aclk(aclk), .we(coef_we), .waddr(idx), .wdata(mr_wdata),
        .raddr(coef_raddr), .rdata(mr_rdata));

    // Source term for the current index.
    logic [25:0] src;
    logic [25:0] gain3;
    assign gain3 = {2'b0, gain} + {1'b0, gain, 1'b0};
    always_comb begin
        priority if (idx >= b1_lo && idx <= b1_hi) begin
            src = {2'b0, gain};
        end else if (idx >= b2_lo && idx <= b2_hi) begin
            src = {2'b0, gain3[25:2]};
        end else begin
            src = '0;
        end
    end

    // Forward sweep registers.
    logic [ihds_pkg::DEN_W-1:0] den_reg;
    logic [55:0]                rd_reg;
    logic [ihds_pkg::NUM_W-1:0] num_reg;
    logic [31:0]                e_new_reg;
    logic [ihds_pkg::DEN_W-1:0] den_next;
    logic [56:0]                rt;
    logic [ihds_pkg::NUM_W-1:0] num_next;

    assign rt = {33'b0, ratio} * ({25'b0, 32'h0} + (57'd1 << 32) - {25'b0, mu_rdata});
    assign den_next = ihds_pkg::DEN_W'((33'd1 << 24) + rt[55:23]);
    assign num_next = ({40'b0, prof_rdata} + {38'b0, src}) << 24;

    logic        div_start;
    logic [ihds_pkg::NUM_W-1:0] div_num;
    logic [ihds_pkg::QUO_W-1:0] div_quo;
    logic        div_busy;

    assign div_start = cmd.div_start_e || cmd.div_start_d;
    assign div_num = cmd.div_start_e ? ({40'b0, ratio} << 39)
                                     : (num_reg + {rd_reg, 8'b0});

    ihds_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(den_reg), .busy(div_busy), .quo(div_quo));

    always_ff @(posedge aclk) begin
        if (cmd.fwd_den) begin
            den_reg <= den_next;
            rd_reg <= {32'b0, ratio} * {24'b0, mr_rdata};
            num_reg <= num_next;
        end
        if (cmd.div_start_d) begin
            e_new_reg <= div_quo[31:0];
        end
    end

    // Forward write: interior rows from the divider, end rows fixed.
    always_comb begin
        coef_we = cmd.fwd_write;
        if (idx == '0) begin
            mu_wdata = 32'h8000_0000;
            mr_wdata = '0;
        end else if (idx == LAST) begin
            mu_wdata = '0;
            mr_wdata = {8'b0, bound_temp};
        end else begin
            mu_wdata = e_new_reg;
            mr_wdata = (div_quo[47:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
        end
    end

    // Back substitution.
    logic [55:0] prod_reg;
    logic [31:0] mr_hold_reg;
    logic [32:0] bsum;
    logic [TW-1:0] bval;
    always_ff @(posedge aclk) begin
        if (cmd.bwd_mul) begin
            prod_reg <= {24'b0, mu_rdata} * {32'b0, prof_rdata};
            mr_hold_reg <= mr_rdata;
        end
    end
    assign bsum = {1'b0, mr_hold_reg} + {8'b0, prod_reg[55:31]};
    assign bval = (bsum > 33'hFF_FFFF) ? {TW{1'b1}} : bsum[TW-1:0];

    always_comb begin
        prof_we = cmd.fill || cmd.bwd_write;
        prof_waddr = idx;
        prof_wdata = cmd.fill ? init_temp : ((idx == LAST) ? bound_temp : bval);
        if (cmd.bwd_read) begin
            prof_raddr = idx + 1'b1;
        end else begin
            prof_raddr = idx;
        end
        if (cmd.fwd_read) begin
            coef_raddr = idx_prev;
        end else begin
            coef_raddr = idx;
        end
    end

    // Output register.
    logic          emit_pend_reg;
    logic [IW-1:0] emit_idx_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
            emit_pend_reg <= 1'b0;
        end else begin
            emit_pend_reg <= cmd.emit_read;
            if (emit_pend_reg) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
        if (cmd.emit_read) begin
            emit_idx_reg <= idx;
        end
        if (emit_pend_reg) begin
            m_idx <= emit_idx_reg;
            m_temp <= prof_rdata;
            m_last <= (emit_idx_reg == LAST);
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_full = m_tvalid || emit_pend_reg;
endmodule
`default_nettype wire

FILE: rtl/ihds_ctrl.sv
`default_nettype none
module ihds_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              reinit,
    input  wire logic              m_tready,
    input  wire ihds_pkg::status_t status,
    output ihds_pkg::cmd_t         cmd
);
    localparam int IW = ihds_pkg::IDX_W;
    localparam logic [IW-1:0] LAST = IW'(ihds_pkg::POINTS - 1);

    ihds_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          start_reg, start_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ihds_pkg::ST_FILL;
            idx_reg <= '0;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            start_reg <= start_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        start_next = 1'b0;
        cmd = '0;
        cmd.idx = idx_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            ihds_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                idx_next = '0;
                if (s_tvalid) begin
                    state_next = reinit ? ihds_pkg::ST_FILL : ihds_pkg::ST_FWD_WRITE;
                end
            end
            ihds_pkg::ST_FILL: begin
                cmd.fill = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST) begin
                    state_next = ihds_pkg::ST_IDLE;
                end
            end
            ihds_pkg::ST_FWD_READ: begin
                cmd.fwd_read = 1'b1;
                state_next = ihds_pkg::ST_FWD_DEN;
            end
            ihds_pkg::ST_FWD_DEN: begin
                cmd.fwd_den = 1'b1;
                start_next = 1'b1;
                state_next = ihds_pkg::ST_FWD_DIVE;
            end
            ihds_pkg::ST_FWD_DIVE: begin
                cmd.div_start_e = start_reg;
                if (!start_reg && !status.div_busy) begin
                    start_next = 1'b1;
                    state_next = ihds_pkg::ST_FWD_DIVD;
                end
            end
            ihds_pkg::ST_FWD_DIVD: begin
                cmd.div_start_d = start_reg;
                if (!start_reg && !status.div_busy) begin
                    state_next = ihds_pkg::ST_FWD_WRITE;
                end
            end
            ihds_pkg::ST_FWD_WRITE: begin
                cmd.fwd_write = 1'b1;
                if (idx_reg == LAST) begin
                    state_next = ihds_pkg::ST_BWD_WRITE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == LAST - 1'b1) ? ihds_pkg::ST_FWD_WRITE
                                                         : ihds_pkg::ST_FWD_READ;
                end
            end
            ihds_pkg::ST_BWD_READ: begin
                cmd.bwd_read = 1'b1;
                state_next = ihds_pkg::ST_BWD_MUL;
            end
            ihds_pkg::ST_BWD_MUL: begin
                cmd.bwd_mul = 1'b1;
                state_next = ihds_pkg::ST_BWD_WRITE;
            end
            ihds_pkg::ST_BWD_WRITE: begin
                cmd.bwd_write = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ihds_pkg::ST_EMIT_READ;
                end else begin
                    idx_next = idx_reg - 1'b1;
                    state_next = ihds_pkg::ST_BWD_READ;
                end
            end
            ihds_pkg::ST_EMIT_READ: begin
                if (!status.out_full || m_tready) begin
                    cmd.emit_read = 1'b1;
                    state_next = ihds_pkg::ST_EMIT_WAIT;
                end
            end
            ihds_pkg::ST_EMIT_WAIT: begin
                if (idx_reg == LAST) begin
                    state_next = ihds_pkg::ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ihds_pkg::ST_EMIT_READ;
                end
            end
            default: begin
                state_next = ihds_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ihds_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_one_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.div_start_e && cmd.div_start_d))
        else $error("two divider starts");
    a_fill_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ihds_pkg::ST_FILL && idx_reg == LAST) |=>
        state_reg == ihds_pkg::ST_IDLE)
        else $error("fill did not end");
`endif
endmodule
`default_nettype wire

FILE: rtl/implicit_heat_diffusion_step_1d.sv
// Reset fill: the profile takes init_temp before the first transaction is taken.
// Reinit transaction: refills the profile, no output transactions.
// Step transaction: a forward sweep over the 62 interior points (two serial
// divisions per point dominate), back substitution from the last point down,
// then 64 output transactions paced by m_tready; one step in flight at a time.
// Synchronous active-low reset clears control state and restores registers.
`default_nettype none
module implicit_heat_diffusion_step_1d (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] reinit
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [5:0] point_index, [29:6] temperature
    output logic             m_tlast
);
    // Configuration registers: the user must write all only while idle (unchecked).
    logic [23:0] ratio_reg, gain_reg, init_reg, bound_reg;
    logic [5:0]  b1_lo_reg, b1_hi_reg, b2_lo_reg, b2_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= 24'd65536;
            gain_reg <= 24'd0;
            init_reg <= 24'd1195171;
            bound_reg <= 24'd1172643;
            b1_lo_reg <= 6'd6;
            b1_hi_reg <= 6'd12;
            b2_lo_reg <= 6'd32;
            b2_hi_reg <= 6'd37;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ihds_pkg::REG_RATIO: ratio_reg <= cfg_data;
                ihds_pkg::REG_GAIN:  gain_reg <= cfg_data;
                ihds_pkg::REG_INIT:  init_reg <= cfg_data;
                ihds_pkg::REG_BOUND: bound_reg <= cfg_data;
                ihds_pkg::REG_B1_LO: b1_lo_reg <= cfg_data[5:0];
                ihds_pkg::REG_B1_HI: b1_hi_reg <= cfg_data[5:0];
                ihds_pkg::REG_B2_LO: b2_lo_reg <= cfg_data[5:0];
                ihds_pkg::REG_B2_HI: b2_hi_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    ihds_pkg::cmd_t    cmd;
    ihds_pkg::status_t status;
    logic [5:0]  m_idx;
    logic [23:0] m_temp;

    // The controller sequences fill, forward sweep, back substitution and emission.
    ihds_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .reinit(s_tdata[0]), .m_tready(m_tready), .status(status), .cmd(cmd));

    ihds_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .ratio(ratio_reg), .gain(gain_reg), .init_temp(init_reg),
        .bound_temp(bound_reg), .b1_lo(b1_lo_reg), .b1_hi(b1_hi_reg),
        .b2_lo(b2_lo_reg), .b2_hi(b2_hi_reg), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_idx(m_idx), .m_temp(m_temp), .m_last(m_tlast));

    assign m_tdata = {2'b00, m_temp, m_idx};
endmodule
`default_nettype wire

FILE: dv/implicit_heat_diffusion_step_1d_tb.sv
`default_nettype none
module implicit_heat_diffusion_step_1d_tb;

    // Generous ceiling on the run: each step is dominated by its serial
    // divisions, and random idling on both sides can stretch it further.
    localparam int CYCLE_LIMIT = 20_000_000;
    // Settling time after the last expected point, or after a reinit.
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [ihds_pkg::IDX_W-1:0]  idx;
        logic [ihds_pkg::TEMP_W-1:0] temp;
        logic                        last;
    } point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [0] reinit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [5:0] point_index, [29:6] temperature
    logic        m_tlast;

    implicit_heat_diffusion_step_1d dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Our own copy of the block's registers and temperature profile.
    logic [23:0] ratio_q = 24'd65536;
    logic [23:0] gain_q = 24'd0;
    logic [23:0] init_temp_q = 24'd1195171;
    logic [23:0] bound_temp_q = 24'd1172643;
    logic [5:0]  b1_lo_q = 6'd6, b1_hi_q = 6'd12, b2_lo_q = 6'd32, b2_hi_q = 6'd37;
    logic [23:0] profile_q [ihds_pkg::POINTS];
    logic [31:0] sweep_upper [ihds_pkg::POINTS];
    logic [31:0] sweep_rhs [ihds_pkg::POINTS];

    point_t      expected_points [$];
    bit          calm = 1'b0;       // when set, neither side idles
    int          errors = 0;
    int          cycles = 0;
    int          steps_sent = 0;
    int          reinits_sent = 0;
    int          points_seen = 0;
    int          cfg_writes = 0;

    initial begin
        for (int i = 0; i < ihds_pkg::POINTS; i++) profile_q[i] = 24'd1195171;
    end

    // Heat source at a grid point: the first band wins where the bands overlap.
    function automatic logic [63:0] source_at(int i);
        if (i >= b1_lo_q && i <= b1_hi_q) return 64'(gain_q);
        if (i >= b2_lo_q && i <= b2_hi_q) return (64'(gain_q) * 3) >> 2;
        return 64'd0;
    endfunction

    // One backward-Euler step by the Thomas algorithm, then the new profile is
    // queued as the points the block must emit.
    task automatic predict_step();
        logic [63:0] r, den, num, quo, rem, v;
        r = 64'(ratio_q);
        sweep_upper[0] = 32'h8000_0000;
        sweep_rhs[0] = 32'd0;
        for (int i = 1; i < ihds_pkg::POINTS - 1; i++) begin
            den = (64'd1 << 24) + ((r * ((64'd1 << 32) - 64'(sweep_upper[i-1]))) >> 23);
            sweep_upper[i] = 32'((r << 39) / den);
            num = ((64'(profile_q[i]) + source_at(i)) << 16) + r * 64'(sweep_rhs[i-1]);
            quo = num / den;
            rem = num % den;
            v = (quo << 8) + ((rem << 8) / den);
            sweep_rhs[i] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
        end
        profile_q[ihds_pkg::POINTS-1] = bound_temp_q;
        for (int i = ihds_pkg::POINTS - 2; i >= 0; i--) begin
            v = 64'(sweep_rhs[i]) + ((64'(sweep_upper[i]) * 64'(profile_q[i+1])) >> 31);
            profile_q[i] = (v > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(v);
        end
        for (int i = 0; i < ihds_pkg::POINTS; i++)
            expected_points.push_back('{idx: ihds_pkg::IDX_W'(i), temp: profile_q[i],
                                        last: (i == ihds_pkg::POINTS - 1)});
    endtask

    // Sends one transaction, with a random gap in front of it unless calm.
    task automatic send_item(input bit reinit);
        if (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, reinit};
        do @(posedge aclk); while (!s_tready);
        if (reinit) begin
            for (int i = 0; i < ihds_pkg::POINTS; i++) profile_q[i] = init_temp_q;
            reinits_sent++;
        end else begin
            predict_step();
            steps_sent++;
        end
    endtask

    // Waits until every expected point has arrived, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write, only ever issued while the block is drained.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            ihds_pkg::REG_RATIO: ratio_q = val;
            ihds_pkg::REG_GAIN:  gain_q = val;
            ihds_pkg::REG_INIT:  init_temp_q = val;
            ihds_pkg::REG_BOUND: bound_temp_q = val;
            ihds_pkg::REG_B1_LO: b1_lo_q = val[5:0];
            ihds_pkg::REG_B1_HI: b1_hi_q = val[5:0];
            ihds_pkg::REG_B2_LO: b2_lo_q = val[5:0];
            ihds_pkg::REG_B2_HI: b2_hi_q = val[5:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic write_bands(input logic [23:0] lo1, hi1, lo2, hi2);
        write_reg(ihds_pkg::REG_B1_LO, lo1);
        write_reg(ihds_pkg::REG_B1_HI, hi1);
        write_reg(ihds_pkg::REG_B2_LO, lo2);
        write_reg(ihds_pkg::REG_B2_HI, hi2);
    endtask

    // Reset values first: two steps with no source, a reinit, then one more step.
    task automatic test_reset_profile();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();
    endtask

    // Extremes of the ratio and of the temperatures, including saturation of
    // the right-hand side and of the final temperature.
    task automatic test_extremes();
        write_reg(ihds_pkg::REG_RATIO, 24'd0);
        write_reg(ihds_pkg::REG_GAIN, 24'hFF_FFFF);
        send_item(1'b0);
        drain();
        write_reg(ihds_pkg::REG_RATIO, 24'hFF_FFFF);
        write_reg(ihds_pkg::REG_BOUND, 24'hFF_FFFF);
        write_reg(ihds_pkg::REG_INIT, 24'hFF_FFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        drain();
        write_reg(ihds_pkg::REG_BOUND, 24'd0);
        write_reg(ihds_pkg::REG_INIT, 24'd0);
        write_reg(ihds_pkg::REG_GAIN, 24'd0);
        send_item(1'b1);
        send_item(1'b0);
        drain();
    endtask

    // Empty bands, overlapping bands (the first must win) and bands that
    // cover both ends of the rod, which must never take a source.
    task automatic test_bands();
        write_reg(ihds_pkg::REG_RATIO, 24'd65536);
        write_reg(ihds_pkg::REG_GAIN, 24'h12_3457);
        write_reg(ihds_pkg::REG_INIT, 24'd1195171);
        write_reg(ihds_pkg::REG_BOUND, 24'd1172643);
        send_item(1'b1);
        drain();
        write_bands(24'd40, 24'd3, 24'd63, 24'd0);
        send_item(1'b0);
        drain();
        write_bands(24'd10, 24'd30, 24'd20, 24'd50);
        send_item(1'b0);
        drain();
        write_bands(24'd0, 24'd63, 24'd0, 24'd63);
        send_item(1'b0);
        drain();
        write_bands(24'hFFFFC0, 24'd5, 24'd58, 24'hFFFFFF);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();
    endtask

    function automatic logic [23:0] pick_value();
        case ($urandom_range(5))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom_range(1 << 20));
            default: return 24'($urandom);
        endcase
    endfunction

    // Random phases: fresh settings, then a run of steps and reinits. The
    // middle phase runs with no idling at all on either side.
    task automatic test_random(input int items);
        int sent;
        int phase;
        sent = 0;
        phase = 0;
        while (sent < items) begin
            write_reg(ihds_pkg::REG_RATIO, ($urandom_range(3) == 0) ? pick_value()
                                           : 24'($urandom_range(1 << 18)));
            write_reg(ihds_pkg::REG_GAIN, ($urandom_range(2) == 0) ? pick_value()
                                          : 24'($urandom_range(1 << 16)));
            write_reg(ihds_pkg::REG_INIT, pick_value());
            write_reg(ihds_pkg::REG_BOUND, pick_value());
            write_bands(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
            calm = (phase == 4);
            for (int k = 0; k < 30 && sent < items; k++) begin
                send_item($urandom_range(99) < 25);
                sent++;
            end
            drain();
            calm = 1'b0;
            phase++;
        end
    endtask

    // Result side: random back-pressure, and each point checked against the
    // oldest expectation.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 22);
    end

    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{idx: m_tdata[5:0], temp: m_tdata[29:6], last: m_tlast};
            points_seen++;
            if (expected_points.size() == 0) begin
                $error("point transaction with nothing expected: index %0d", got.idx);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (got.idx !== want.idx) begin
                    $error("point_index: expected %0d, got %0d", want.idx, got.idx);
                    errors++;
                end
                if (got.temp !== want.temp) begin
                    $error("temperature: expected %0d, got %0d", want.temp, got.temp);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last_point: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed out with %0d points outstanding", expected_points.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_profile();
        test_extremes();
        test_bands();
        test_random(270);
        drain();
        $display("%0d steps and %0d reinits sent, %0d register writes, %0d points checked",
                 steps_sent, reinits_sent, cfg_writes, points_seen);
        $display("covered extreme ratios and temperatures, saturation, empty, overlapping and end bands");
        if (errors == 0 && expected_points.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
